// File: rtl/cdhr_pkg.sv
// Shared types and constants for the cartoon darkening filter.
// Depends on nothing; only the top level imports it.
package cdhr_pkg;

  localparam int PIX_W      = 8;
  localparam int CHANS      = 3;
  localparam int LEVELS     = 256;
  localparam int LVL_W      = 8;
  localparam int RAMP_W     = 9;
  localparam int WIN_W      = 4;
  localparam int THR_W      = 10;
  localparam int PCT_W      = 9;
  localparam int DIM_W      = 8;
  localparam int NUM_MIN_W  = 24;   // p * ws^2 * 256 at most
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERCENTILE = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] chan0_in;
    logic [PIX_W-1:0] chan1_in;
    logic [PIX_W-1:0] chan2_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] chan0_out;
    logic [PIX_W-1:0] chan1_out;
    logic [PIX_W-1:0] chan2_out;
    logic             last_pixel;
    logic             not_ready;
  } out_item_t;

endpackage

// File: rtl/cdhr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cdhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cdhr_div.sv
// Restoring divider, one quotient bit per cycle.
// Does not use cdhr_pkg; no submodules.
module cdhr_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W-1:0] dsor;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quot[NUM_W-1]};
    diff  = trial - {1'b0, dsor};
    ge    = trial >= {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= num;
        rem  <= '0;
        dsor <= den;
        cnt  <= CW'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem  <= diff[DEN_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial[DEN_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/cartoon_darken_histogram_ramp.sv
// Top level of the cartoon darkening filter: sequencer, frame store, histogram.
// Depends on cdhr_pkg, cdhr_ram and cdhr_div.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_data  (kind, chan0..2_in)
//  out     | out_valid/out_ready  | out_data (chan0..2_out, last_pixel, not_ready)
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// A load makes three histogram read-modify-writes; the load that completes the
// frame adds a ramp search over 256 histogram rows. A fetch after the frame is
// loaded uses the one shared serial divider (position, ratio and scale) and the
// single store read port. Reset and end of frame run a histogram clearing pass
// over every row, not ready. in_ready drops while an item is at work; a stalled
// output holds the sequencer.
module cartoon_darken_histogram_ramp #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WINDOW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cdhr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cdhr_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cdhr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cdhr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cdhr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 2 * DIM_W) ? CNT_W : 2 * DIM_W;
  localparam int X_W   = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int NUM_W = (CNT_W > NUM_MIN_W) ? CNT_W : NUM_MIN_W;
  localparam int DEN_W = (SUM_W > RAMP_W) ? SUM_W : RAMP_W;
  localparam int HW    = CHANS * CNT_W;
  localparam int P_W   = CNT_W + PCT_W;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_SR_PREP, S_SR_RD, S_SR_UP,
    S_F_DIV, S_F_DIVW, S_WIN, S_WIN_DR, S_CH, S_CH_D1W, S_CH_CMP,
    S_CH_D2W, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [WIN_W-1:0] window_size;
  logic [THR_W-1:0] threshold_level;
  logic [PCT_W-1:0] ramp_percentile;

  // effective frame geometry
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [WIN_W-1:0]   ws_eff;
  logic [2*DIM_W-1:0] total;
  logic               load_open;
  logic               last_f;

  // frame bookkeeping
  logic [CNT_W-1:0]  load_count, emit_count;
  logic [RAMP_W-1:0] ramp [CHANS];
  logic [LVL_W-1:0]  idx;
  logic [1:0]        ch;
  logic [PIX_W-1:0]  vin [CHANS];
  logic              nr;

  // ramp search
  logic [P_W-1:0]   prod;
  logic [CNT_W-1:0] cum [CHANS];
  logic [CNT_W-1:0] cum_nx [CHANS];
  logic [CHANS-1:0] found, hit;

  // window walk
  logic [CNT_W-1:0] x;
  logic [DIM_W-1:0] y;
  logic [WIN_W-1:0] dx, dy;
  logic [AW-1:0]    addr, col;
  logic             pend, el_ok;
  logic [SUM_W-1:0] sum [CHANS];
  logic [PIX_W-1:0] pix [CHANS];
  logic [PIX_W-1:0] res [CHANS];
  logic [2*WIN_W-1:0] wsq;

  // channel arithmetic
  logic [PIX_W-1:0]        p_ch;
  logic [RAMP_W-1:0]       r_ch;
  logic [2*PIX_W-1:0]      mul_ratio;
  logic [THR_W-1:0]        d_gap;
  logic [THR_W-1:0]        m_gap;
  logic [RAMP_W-1:0]       keep;
  logic [PIX_W+RAMP_W-1:0] mul_scale;
  logic                    below;

  // memories
  logic                 fs_we;
  logic [AW-1:0]        fs_waddr, fs_raddr;
  logic [CHANS*PIX_W-1:0] fs_wdata, fs_rdata;
  logic                 h_we;
  logic [LVL_W-1:0]     h_waddr, h_raddr;
  logic [HW-1:0]        h_wdata, h_rdata;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den, div_rem;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= DIM_W'(128);
      frame_height    <= DIM_W'(128);
      window_size     <= WIN_W'(5);
      threshold_level <= THR_W'(256);
      ramp_percentile <= PCT_W'(230);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[DIM_W-1:0];
        CFG_WINDOW_SIZE:     window_size     <= cfg_data[WIN_W-1:0];
        CFG_THRESHOLD_LEVEL: threshold_level <= cfg_data[THR_W-1:0];
        CFG_RAMP_PERCENTILE: ramp_percentile <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the geometry into the supported range
  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) w_eff = DIM_W'(1);
    else if (int'(frame_width) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height == '0) h_eff = DIM_W'(1);
    else if (int'(frame_height) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    ws_eff = window_size;
    if (window_size == '0) ws_eff = WIN_W'(1);
    else if (int'(window_size) > MAX_WINDOW) ws_eff = WIN_W'(MAX_WINDOW);
    total     = w_eff * h_eff;
    load_open = CMP_W'(load_count) < CMP_W'(total);
    last_f    = (CMP_W'(emit_count) + CMP_W'(1)) >= CMP_W'(total);
  end

  // histogram accumulation and ramp hits, one row of three bins per step
  always_comb begin
    for (int k = 0; k < CHANS; k++) begin
      cum_nx[k] = cum[k] + h_rdata[k*CNT_W +: CNT_W];
      hit[k]    = !found[k] && (P_W'({cum_nx[k], 8'h00}) > prod);
    end
  end

  // window element inside the clipped frame
  assign el_ok = (X_W'(x) + X_W'(dx) < X_W'(w_eff)) &&
                 ((DIM_W+1)'(y) + (DIM_W+1)'(dy) < (DIM_W+1)'(h_eff));

  // per-channel darkening arithmetic
  always_comb begin
    p_ch      = pix[ch];
    r_ch      = ramp[ch];
    mul_ratio = p_ch * wsq;
    below     = div_quot < NUM_W'(threshold_level);
    d_gap     = threshold_level - div_quot[THR_W-1:0];
    m_gap     = (d_gap < THR_W'(r_ch)) ? d_gap : THR_W'(r_ch);
    keep      = r_ch - m_gap[RAMP_W-1:0];
    mul_scale = p_ch * keep;
  end

  always_comb begin
    fs_we    = in_valid && in_ready && (in_data.kind == KIND_LOAD) && load_open;
    fs_waddr = load_count[AW-1:0];
    fs_wdata = {in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};
    fs_raddr = (state == S_WIN) ? addr : emit_count[AW-1:0];

    h_raddr = (state == S_LD_RD) ? vin[ch] : idx;
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = '0;
    if (state == S_CLR) begin
      h_we = 1'b1;
    end else if (state == S_LD_WR) begin
      h_we    = 1'b1;
      h_waddr = vin[ch];
      h_wdata = h_rdata;
      for (int k = 0; k < CHANS; k++) begin
        if (2'(k) == ch) begin
          h_wdata[k*CNT_W +: CNT_W] = h_rdata[k*CNT_W +: CNT_W] + CNT_W'(1);
        end
      end
    end

    div_start = 1'b0;
    div_num   = NUM_W'(emit_count);
    div_den   = DEN_W'(h_eff);
    unique case (state)
      S_F_DIV: div_start = 1'b1;
      S_CH: begin
        div_start = (sum[ch] != '0);
        div_num   = NUM_W'({mul_ratio, 8'h00});
        div_den   = DEN_W'(sum[ch]);
      end
      S_CH_CMP: begin
        div_start = below && (r_ch != '0);
        div_num   = NUM_W'(mul_scale);
        div_den   = DEN_W'(r_ch);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      idx        <= '0;
      load_count <= '0;
      emit_count <= '0;
      out_valid  <= 1'b0;
      for (int k = 0; k < CHANS; k++) ramp[k] <= '0;
    end else begin
      // S_OUT sets the output itself; elsewhere an accepted item clears it
      if (out_ready && (state != S_OUT)) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          idx <= idx + LVL_W'(1);
          if (idx == LVL_W'(LEVELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            vin[0] <= in_data.chan0_in;
            vin[1] <= in_data.chan1_in;
            vin[2] <= in_data.chan2_in;
            ch     <= 2'd0;
            nr     <= 1'b0;
            if (in_data.kind == KIND_LOAD) begin
              if (load_open) state <= S_LD_RD;   // loads past the frame are dropped
            end else if (load_open) begin
              nr    <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_F_DIV;
            end
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          if (ch == 2'd2) begin
            load_count <= load_count + CNT_W'(1);
            if (CMP_W'(load_count) + CMP_W'(1) == CMP_W'(total)) state <= S_SR_PREP;
            else state <= S_IDLE;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_LD_RD;
          end
        end
        S_SR_PREP: begin
          prod  <= P_W'(ramp_percentile) * P_W'(load_count);
          idx   <= '0;
          found <= '0;
          for (int k = 0; k < CHANS; k++) begin
            cum[k]  <= '0;
            ramp[k] <= '0;
          end
          state <= S_SR_RD;
        end
        S_SR_RD: state <= S_SR_UP;
        S_SR_UP: begin
          for (int k = 0; k < CHANS; k++) begin
            cum[k] <= cum_nx[k];
            if (hit[k]) begin
              ramp[k]  <= RAMP_W'(LEVELS) - RAMP_W'(idx);
              found[k] <= 1'b1;
            end
          end
          idx <= idx + LVL_W'(1);
          if (idx == LVL_W'(LEVELS - 1)) state <= S_IDLE;
          else state <= S_SR_RD;
        end
        S_F_DIV: begin
          wsq   <= ws_eff * ws_eff;
          state <= S_F_DIVW;
        end
        S_F_DIVW: begin
          // store read port has sat on emit_count, so the current pixel is ready
          if (div_done) begin
            x    <= div_quot[CNT_W-1:0];
            y    <= div_rem[DIM_W-1:0];
            dx   <= '0;
            dy   <= '0;
            addr <= emit_count[AW-1:0];
            col  <= emit_count[AW-1:0];
            pend <= 1'b0;
            for (int k = 0; k < CHANS; k++) begin
              pix[k] <= fs_rdata[k*PIX_W +: PIX_W];
              sum[k] <= '0;
            end
            state <= S_WIN;
          end
        end
        S_WIN: begin
          pend <= el_ok;
          if (pend) begin
            for (int k = 0; k < CHANS; k++)
              sum[k] <= sum[k] + SUM_W'(fs_rdata[k*PIX_W +: PIX_W]);
          end
          if (dy == ws_eff - WIN_W'(1)) begin
            dy   <= '0;
            dx   <= dx + WIN_W'(1);
            col  <= col + AW'(h_eff);
            addr <= col + AW'(h_eff);
            if (dx == ws_eff - WIN_W'(1)) state <= S_WIN_DR;
          end else begin
            dy   <= dy + WIN_W'(1);
            addr <= addr + AW'(1);
          end
        end
        S_WIN_DR: begin
          if (pend) begin
            for (int k = 0; k < CHANS; k++)
              sum[k] <= sum[k] + SUM_W'(fs_rdata[k*PIX_W +: PIX_W]);
          end
          ch    <= 2'd0;
          state <= S_CH;
        end
        S_CH: begin
          if (sum[ch] == '0) begin
            res[ch] <= p_ch;
            if (ch == 2'd2) state <= S_OUT;
            else ch <= ch + 2'd1;
          end else begin
            state <= S_CH_D1W;
          end
        end
        S_CH_D1W: if (div_done) state <= S_CH_CMP;
        S_CH_CMP: begin
          if (below && (r_ch != '0)) begin
            state <= S_CH_D2W;
          end else begin
            res[ch] <= below ? '0 : p_ch;
            if (ch == 2'd2) state <= S_OUT;
            else begin
              ch    <= ch + 2'd1;
              state <= S_CH;
            end
          end
        end
        S_CH_D2W: begin
          if (div_done) begin
            res[ch] <= div_quot[PIX_W-1:0];
            if (ch == 2'd2) state <= S_OUT;
            else begin
              ch    <= ch + 2'd1;
              state <= S_CH;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (nr) begin
              out_data <= '{chan0_out: '0, chan1_out: '0, chan2_out: '0,
                            last_pixel: 1'b0, not_ready: 1'b1};
              state    <= S_IDLE;
            end else begin
              out_data <= '{chan0_out: res[0], chan1_out: res[1], chan2_out: res[2],
                            last_pixel: last_f, not_ready: 1'b0};
              if (last_f) begin
                // frame done: restart counts and sweep the histogram clean
                load_count <= '0;
                emit_count <= '0;
                idx        <= '0;
                state      <= S_CLR;
              end else begin
                emit_count <= emit_count + CNT_W'(1);
                state      <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  cdhr_ram #(.WIDTH(CHANS * PIX_W), .DEPTH(DEPTH)) u_frame (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  cdhr_ram #(.WIDTH(HW), .DEPTH(LEVELS)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  cdhr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );
endmodule
